>>> hw/rtl/bqf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqf_pkg: shared constants for the biquad TDF-II filter
// Default field widths, digit size of the serial multipliers and the
// configuration register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package bqf_pkg;

	// default widths
	localparam int SAMPLE_WIDTH_DEF   = 24;
	localparam int COEF_FRAC_BITS_DEF = 16;

	// multiplier digit: bits of the sample consumed per cycle
	localparam int DIGIT_WIDTH = 8;

	// configuration register indexes
	localparam int CFG_INDEX_WIDTH = 3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_B0 = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_B1 = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_B2 = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_A1 = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_A2 = 3'd4;

	// sequencer states, one-hot
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_MULX  = 7'b0000010,
		S_SUM   = 7'b0000100,
		S_ROUND = 7'b0001000,
		S_MULY  = 7'b0010000,
		S_DIFF  = 7'b0100000,
		S_SAT   = 7'b1000000
	} bqf_state_t;

endpackage
`default_nettype wire

>>> hw/rtl/biquad_tdf2_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_tdf2_filter: second-order IIR section, transposed direct form II
// Three digit-serial multiplier lanes share one sample digit stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / sample_in) takes one signed sample
//   per request. Output channel (out_valid / out_stall / sample_out /
//   clipped) returns one filtered sample per input request, in order.
//   Coefficients b0, b1, b2, a1, a2 (signed Q3.COEF_FRAC_BITS) are written
//   through cfg_we / cfg_index / cfg_data while the filter is idle; an
//   index past a2 is ignored.
// Sequence (ND = ceil(SAMPLE_WIDTH / 8), 3 for 24-bit samples):
//   The feedforward products run over the ND digits of x (one 8-bit digit of
//   x per cycle in each lane), the feedback products over the ND digits of
//   y, and four steps add, round, subtract and saturate. The result is
//   written to the output register in the final step, and only then does
//   the filter return to idle and take the next input request.
// Reset: delay state cleared, b0 = 1.0, other coefficients zero (pass-through).
// Stall: a finished result waits in the output register; a new input is
//   accepted meanwhile, and its result is held in the final step until the
//   output register is free.
// ----------------------------------------------------------------------------
module biquad_tdf2_filter import bqf_pkg::*; #(
	parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// input channel
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire  signed [SAMPLE_WIDTH-1:0]        sample_in,
	// output channel
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]        sample_out,
	output logic                                  clipped,
	// configuration write port
	input  wire                                   cfg_we,
	input  wire         [CFG_INDEX_WIDTH-1:0]     cfg_index,
	input  wire  signed [COEF_FRAC_BITS+2:0]      cfg_data
);

	localparam int CW   = COEF_FRAC_BITS + 3;               // coefficient width
	localparam int DW   = SAMPLE_WIDTH + COEF_FRAC_BITS + 4; // delay width
	localparam int WW   = DW + 2;                            // working sum width
	localparam int PW   = CW + SAMPLE_WIDTH;                 // exact product width
	localparam int D    = DIGIT_WIDTH;
	localparam int ND   = (SAMPLE_WIDTH + D - 1) / D;        // digits per operand
	localparam int XW   = ND * D;                            // padded operand width
	localparam int HW   = CW + 1;                            // lane upper part
	localparam int SUMW = CW + D + 1;                        // lane adder width
	localparam int CNTW = (ND > 1) ? $clog2(ND) : 1;
	localparam int NLANE = 3;

	localparam logic signed [WW-1:0] HALF = WW'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [WW-1:0] YMAX = {{(WW-SAMPLE_WIDTH+1){1'b0}},
		{(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [WW-1:0] YMIN = ~YMAX;
	localparam logic signed [WW-1:0] DMAX = {{(WW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [WW-1:0] DMIN = ~DMAX;

	bqf_state_t state_q;
	logic [CNTW-1:0] step_q;

	// coefficients
	logic signed [CW-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;

	// delay state
	logic signed [DW-1:0] d1_q, d2_q;

	// serial multiplier: operand digit stream and per-lane partial product
	logic        [XW-1:0] mul_q;
	logic signed [HW-1:0] hi_q [NLANE];
	logic        [XW-1:0] lo_q [NLANE];

	// intermediate sums
	logic signed [WW-1:0] acc_q, t1_q, pb2_q, n1_q, n2_q;
	logic                 clip_q;

	// rounded output held for the result register
	logic signed [SAMPLE_WIDTH-1:0] y_hold_q;

	// output register
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
	logic                           clipped_q;

	logic                    last_digit;
	logic        [D-1:0]     digit;
	logic signed [D:0]       digit_ext;
	logic signed [CW-1:0]    lane_coef [NLANE];
	logic signed [SUMW-1:0]  lane_sum  [NLANE];
	logic signed [WW-1:0]    lane_prod [NLANE];
	logic        [HW+XW-1:0] lane_full [NLANE];
	logic signed [WW-1:0]    y_shift;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;
	logic                    y_clip;
	logic signed [DW-1:0]    n1_sat, n2_sat;
	logic                    n1_clip, n2_clip;
	logic                    out_free;

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;
	assign out_free   = !out_valid_q || !out_stall;

	// digit select: the top digit carries the sign
	assign last_digit = (step_q == CNTW'(ND - 1));
	assign digit      = mul_q[D-1:0];
	assign digit_ext  = last_digit ? {digit[D-1], digit} : {1'b0, digit};

	// lane coefficients: b0/b1/b2 on x, a1/a2 on y
	always_comb begin
		if (state_q == S_MULY) begin
			lane_coef[0] = a1_q;
			lane_coef[1] = a2_q;
			lane_coef[2] = '0;
		end else begin
			lane_coef[0] = b0_q;
			lane_coef[1] = b1_q;
			lane_coef[2] = b2_q;
		end
	end

	// per-lane digit multiply-accumulate and assembled product
	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			lane_sum[i]  = SUMW'(hi_q[i]) + SUMW'(lane_coef[i]) * SUMW'(digit_ext);
			lane_full[i] = {hi_q[i], lo_q[i]};
			lane_prod[i] = WW'(signed'(lane_full[i][PW-1:0]));
		end
	end

	// output rounding (floor after adding half) and saturation
	always_comb begin
		y_shift = acc_q >>> COEF_FRAC_BITS;
		y_clip  = 1'b0;
		if (y_shift > YMAX) begin
			y_sat  = YMAX[SAMPLE_WIDTH-1:0];
			y_clip = 1'b1;
		end else if (y_shift < YMIN) begin
			y_sat  = YMIN[SAMPLE_WIDTH-1:0];
			y_clip = 1'b1;
		end else begin
			y_sat = y_shift[SAMPLE_WIDTH-1:0];
		end
	end

	// delay saturation
	always_comb begin
		n1_clip = 1'b0;
		n2_clip = 1'b0;
		if (n1_q > DMAX) begin
			n1_sat  = DMAX[DW-1:0];
			n1_clip = 1'b1;
		end else if (n1_q < DMIN) begin
			n1_sat  = DMIN[DW-1:0];
			n1_clip = 1'b1;
		end else begin
			n1_sat = n1_q[DW-1:0];
		end
		if (n2_q > DMAX) begin
			n2_sat  = DMAX[DW-1:0];
			n2_clip = 1'b1;
		end else if (n2_q < DMIN) begin
			n2_sat  = DMIN[DW-1:0];
			n2_clip = 1'b1;
		end else begin
			n2_sat = n2_q[DW-1:0];
		end
	end

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= CW'(1) << COEF_FRAC_BITS;
			b1_q <= '0;
			b2_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_B0: b0_q <= cfg_data;
				REG_B1: b1_q <= cfg_data;
				REG_B2: b2_q <= cfg_data;
				REG_A1: a1_q <= cfg_data;
				REG_A2: a2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer, delay state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			d1_q        <= '0;
			d2_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a taken result frees the register unless the final step refills it
			if (out_valid_q && !out_stall && state_q != S_SAT)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MULX;
						step_q  <= '0;
					end
				end
				S_MULX: begin
					step_q <= step_q + CNTW'(1);
					if (last_digit)
						state_q <= S_SUM;
				end
				S_SUM: begin
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					state_q <= S_MULY;
					step_q  <= '0;
				end
				S_MULY: begin
					step_q <= step_q + CNTW'(1);
					if (last_digit)
						state_q <= S_DIFF;
				end
				S_DIFF: begin
					state_q <= S_SAT;
				end
				S_SAT: begin
					if (out_free) begin
						d1_q        <= n1_sat;
						d2_q        <= n2_sat;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mul_q <= XW'(sample_in);
				for (int i = 0; i < NLANE; i++)
					hi_q[i] <= '0;
			end
			S_MULX, S_MULY: begin
				mul_q <= mul_q >> D;
				for (int i = 0; i < NLANE; i++) begin
					hi_q[i] <= HW'(lane_sum[i] >>> D);
					lo_q[i] <= (lo_q[i] >> D) | (XW'(lane_sum[i][D-1:0]) << (XW - D));
				end
			end
			S_SUM: begin
				acc_q <= lane_prod[0] + WW'(d1_q) + HALF;
				t1_q  <= lane_prod[1] + WW'(d2_q);
				pb2_q <= lane_prod[2];
			end
			S_ROUND: begin
				mul_q        <= XW'(y_sat);
				sample_out_q <= sample_out_q;
				clip_q       <= y_clip;
				for (int i = 0; i < NLANE; i++)
					hi_q[i] <= '0;
			end
			S_DIFF: begin
				n1_q <= t1_q - lane_prod[0];
				n2_q <= pb2_q - lane_prod[1];
			end
			S_SAT: begin
				if (out_free) begin
					sample_out_q <= y_hold_q;
					clipped_q    <= clip_q | n1_clip | n2_clip;
				end
			end
			default: ;
		endcase
	end

	// rounded output held for the result register
	always_ff @(posedge clk) begin
		if (state_q == S_ROUND)
			y_hold_q <= y_sat;
	end

endmodule
`default_nettype wire
